// ===== rtl/core/bdq_pkg.sv =====
// Shared types, constants and ring-index helpers for the bounded deque.
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int VALUE_W    = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FWD   = 3'd4,
        OP_READ_BWD   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_READ = 2'd2
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic                       at_back;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    // base + off modulo DEPTH; base < DEPTH and off < DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/bdq_if.sv =====
// Request and response channel interfaces of the bounded deque.
interface bdq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [bdq_pkg::OP_W-1:0]             operation;
    logic signed [bdq_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bdq_pkg::VALUE_W-1:0]   result_value;
    logic [bdq_pkg::STATUS_W-1:0]         status;
    logic                                 last;

    modport source (output valid, output result_value, output status, output last,
                    input ready);
    modport sink   (input valid, input result_value, input status, input last,
                    output ready);
endinterface

// ===== rtl/core/bounded_deque_core.sv =====
// Top level of the bounded deque: front end, command queue and back end.
// A double-ended queue of 16 signed 32-bit words in a ring buffer. Each request
// beat carries one operation (push front/back, pop front/back, read forward or
// backward); codes 6 and 7 are taken and produce nothing. Push and pop each
// return one response beat; a push into a full deque is dropped with status
// full, a pop or read of an empty deque returns status empty. A read-out first
// enters a read state, then returns one response beat per stored element, with
// last on the final one, as the back end reads the ring buffer through a single
// port one element per beat. A two-entry command queue lets the front end keep
// taking requests while the back end works or the response register waits;
// storage holds no defined value until written.
module bounded_deque_core (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    request,
    bdq_rsp_if.source  response
);

    logic            cmdq_push;
    bdq_pkg::cmd_t   cmdq_wr_cmd;
    logic            cmdq_full;
    logic            cmdq_valid;
    bdq_pkg::cmd_t   cmdq_rd_cmd;
    logic            cmdq_pop;

    bdq_front u_front (
        .request   (request),
        .cmdq_full (cmdq_full),
        .cmdq_push (cmdq_push),
        .cmdq_cmd  (cmdq_wr_cmd)
    );

    bdq_cmd_fifo u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmdq_push),
        .wr_cmd   (cmdq_wr_cmd),
        .full     (cmdq_full),
        .rd_valid (cmdq_valid),
        .rd_cmd   (cmdq_rd_cmd),
        .rd_en    (cmdq_pop)
    );

    bdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmdq_valid),
        .cmd       (cmdq_rd_cmd),
        .cmd_pop   (cmdq_pop),
        .response  (response)
    );

endmodule

// ===== rtl/core/bdq_front.sv =====
// Front end: accepts request beats and decodes them into queue commands.
module bdq_front (
    bdq_req_if.sink          request,
    input  logic             cmdq_full,
    output logic             cmdq_push,
    output bdq_pkg::cmd_t    cmdq_cmd
);

    bdq_pkg::op_t op;
    logic         known;

    assign op = bdq_pkg::op_t'(request.operation);

    always_comb
    begin
        known            = 1'b1;
        cmdq_cmd.value   = request.value;
        cmdq_cmd.kind    = bdq_pkg::KIND_PUSH;
        cmdq_cmd.at_back = 1'b0;
        unique case (op) inside
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK:
            begin
                cmdq_cmd.kind    = bdq_pkg::KIND_PUSH;
                cmdq_cmd.at_back = (op == bdq_pkg::OP_PUSH_BACK);
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK:
            begin
                cmdq_cmd.kind    = bdq_pkg::KIND_POP;
                cmdq_cmd.at_back = (op == bdq_pkg::OP_POP_BACK);
            end
            bdq_pkg::OP_READ_FWD, bdq_pkg::OP_READ_BWD:
            begin
                cmdq_cmd.kind    = bdq_pkg::KIND_READ;
                cmdq_cmd.at_back = (op == bdq_pkg::OP_READ_BWD);
            end
            default:
            begin
                // unknown codes are taken and dropped
                known = 1'b0;
            end
        endcase
    end

    assign request.ready = !cmdq_full;
    assign cmdq_push     = request.valid && !cmdq_full && known;

endmodule

// ===== rtl/core/bdq_cmd_fifo.sv =====
// Short command queue between the front and back ends.
module bdq_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  bdq_pkg::cmd_t    wr_cmd,
    output logic             full,
    output logic             rd_valid,
    output bdq_pkg::cmd_t    rd_cmd,
    input  logic             rd_en
);

    bdq_pkg::cmd_t                      slots_reg [bdq_pkg::CMDQ_DEPTH];
    logic [bdq_pkg::CMDQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bdq_pkg::CMDQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bdq_pkg::CMDQ_CNT_W-1:0]     count_reg, count_next;
    logic                               do_wr, do_rd;

    assign full     = (count_reg == bdq_pkg::CMDQ_CNT_W'(bdq_pkg::CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == bdq_pkg::CMDQ_PTR_W'(bdq_pkg::CMDQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + bdq_pkg::CMDQ_PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == bdq_pkg::CMDQ_PTR_W'(bdq_pkg::CMDQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + bdq_pkg::CMDQ_PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + bdq_pkg::CMDQ_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - bdq_pkg::CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/core/bdq_back.sv =====
// Back end: ring buffer, deque pointers, read-out sequencer and response register.
module bdq_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  bdq_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    bdq_rsp_if.source        response
);

    logic signed [bdq_pkg::VALUE_W-1:0] mem [bdq_pkg::DEPTH];

    bdq_pkg::back_state_t               state_reg, state_next;
    logic [bdq_pkg::IDX_W-1:0]          front_reg, front_next;
    logic [bdq_pkg::CNT_W-1:0]          occ_reg, occ_next;
    logic [bdq_pkg::IDX_W-1:0]          rd_cnt_reg, rd_cnt_next;

    logic                               out_valid_reg;
    logic signed [bdq_pkg::VALUE_W-1:0] out_value_reg;
    bdq_pkg::status_t                   out_status_reg;
    logic                               out_last_reg;

    logic                               load_ok;
    logic                               emit, emit_from_mem, emit_last;
    bdq_pkg::status_t                   emit_status;
    logic                               wr_en;
    logic [bdq_pkg::IDX_W-1:0]          wr_idx, rd_idx;
    logic [bdq_pkg::CNT_W-1:0]          rd_off, rd_cnt_ext;

    assign load_ok    = !out_valid_reg || response.ready;
    assign rd_cnt_ext = bdq_pkg::CNT_W'(rd_cnt_reg);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        occ_next      = occ_reg;
        rd_cnt_next   = rd_cnt_reg;
        cmd_pop       = 1'b0;
        emit          = 1'b0;
        emit_from_mem = 1'b0;
        emit_last     = 1'b1;
        emit_status   = bdq_pkg::ST_OK;
        wr_en         = 1'b0;
        wr_idx        = front_reg;
        rd_idx        = front_reg;
        rd_off        = cmd.at_back ? (occ_reg - bdq_pkg::CNT_W'(1) - rd_cnt_ext) : rd_cnt_ext;

        unique case (state_reg)
            bdq_pkg::BK_IDLE:
            begin
                if (cmd_valid && load_ok)
                begin
                    unique case (cmd.kind)
                        bdq_pkg::KIND_PUSH:
                        begin
                            emit    = 1'b1;
                            cmd_pop = 1'b1;
                            if (occ_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
                            begin
                                emit_status = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + bdq_pkg::CNT_W'(1);
                                if (cmd.at_back)
                                begin
                                    wr_idx = bdq_pkg::ring_add(front_reg, occ_reg);
                                end
                                else
                                begin
                                    wr_idx     = bdq_pkg::ring_dec(front_reg);
                                    front_next = wr_idx;
                                end
                            end
                        end
                        bdq_pkg::KIND_POP:
                        begin
                            emit    = 1'b1;
                            cmd_pop = 1'b1;
                            if (occ_reg == '0)
                            begin
                                emit_status = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                emit_from_mem = 1'b1;
                                occ_next      = occ_reg - bdq_pkg::CNT_W'(1);
                                if (cmd.at_back)
                                begin
                                    rd_idx = bdq_pkg::ring_add(front_reg,
                                                               occ_reg - bdq_pkg::CNT_W'(1));
                                end
                                else
                                begin
                                    rd_idx     = front_reg;
                                    front_next = bdq_pkg::ring_add(front_reg,
                                                                   bdq_pkg::CNT_W'(1));
                                end
                            end
                        end
                        bdq_pkg::KIND_READ:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit        = 1'b1;
                                cmd_pop     = 1'b1;
                                emit_status = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_cnt_next = '0;
                                state_next  = bdq_pkg::BK_READ;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            bdq_pkg::BK_READ:
            begin
                // one element a beat; hold the command at the queue head until the last
                if (load_ok)
                begin
                    emit          = 1'b1;
                    emit_from_mem = 1'b1;
                    rd_idx        = bdq_pkg::ring_add(front_reg, rd_off);
                    emit_last     = (rd_cnt_ext + bdq_pkg::CNT_W'(1) == occ_reg);
                    if (emit_last)
                    begin
                        cmd_pop    = 1'b1;
                        state_next = bdq_pkg::BK_IDLE;
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + bdq_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = bdq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::BK_IDLE;
            front_reg     <= '0;
            occ_reg       <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            rd_cnt_reg <= rd_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= cmd.value;
        end
        if (emit)
        begin
            out_value_reg  <= emit_from_mem ? mem[rd_idx] : '0;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.result_value = out_value_reg;
    assign response.status       = out_status_reg;
    assign response.last         = out_last_reg;

endmodule

// ===== rtl/core/bdq_checker.sv =====
// Port-level checks on the bounded deque, bound to the top level.
module bdq_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic signed [bdq_pkg::VALUE_W-1:0] rsp_value,
    input logic [bdq_pkg::STATUS_W-1:0]       rsp_status,
    input logic                               rsp_last
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
                                    && $stable(rsp_status) && $stable(rsp_last))
        else $error("response beat changed while stalled");

    // only a read-out gives more than one beat, and those all report ok
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_status == bdq_pkg::ST_OK)
        else $error("non-final beat with error status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != bdq_pkg::ST_OK |-> rsp_value == '0 && rsp_last)
        else $error("error beat with data or without last");

endmodule

bind bounded_deque_core bdq_checker u_bdq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (response.valid),
    .rsp_ready  (response.ready),
    .rsp_value  (response.result_value),
    .rsp_status (response.status),
    .rsp_last   (response.last)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the bounded deque core: predictor, driver, monitor.
module tb_top;
    import bdq_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT      = 40000;
    localparam int TAIL_CYCLES      = 32;

    typedef struct {
        logic [OP_W-1:0]            operation;
        logic signed [VALUE_W-1:0]  value;
    } req_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0]  result_value;
        status_t                    status;
        logic                       last;
    } rsp_beat_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } walk_mode_t;

    logic clk;
    logic rst_n;

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    // predicted deque contents
    logic signed [VALUE_W-1:0] deque_slots [DEPTH];
    logic [IDX_W-1:0]          deque_head;
    logic [CNT_W-1:0]          deque_fill;

    req_item_t pending_reqs [$];
    rsp_beat_t expected_beats [$];
    rsp_beat_t due_beat;

    int  mismatches   = 0;
    int  items_taken  = 0;
    int  noise_taken  = 0;
    int  beats_seen   = 0;
    int  full_hits    = 0;
    int  empty_hits   = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    int  gen_fill     = 0;
    logic req_took    = 1'b0;
    logic offer_held  = 1'b0;
    logic quiet_tail  = 1'b0;
    logic hold_go     = 1'b0;
    logic long_hold   = 1'b0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [IDX_W-1:0] wrap_slot(input int base, input int off);
        return IDX_W'((base + off) % DEPTH);
    endfunction

    task automatic add_beat(input logic signed [VALUE_W-1:0] word, input status_t st,
                            input logic fin);
        rsp_beat_t beat;
        beat.result_value = word;
        beat.status       = st;
        beat.last         = fin;
        expected_beats.push_back(beat);
    endtask

    task automatic predict_deque(input logic [OP_W-1:0] operation,
                                 input logic signed [VALUE_W-1:0] word);
        logic [IDX_W-1:0] slot;
        int n;
        int off;
        case (operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (deque_fill == DEPTH)
                begin
                    add_beat('0, ST_FULL, 1'b1);
                    full_hits++;
                end
                else
                begin
                    if (operation == OP_PUSH_FRONT)
                    begin
                        deque_head = wrap_slot(deque_head, DEPTH - 1);
                        slot = deque_head;
                    end
                    else
                    begin
                        slot = wrap_slot(deque_head, deque_fill);
                    end
                    deque_slots[slot] = word;
                    deque_fill = deque_fill + 1'b1;
                    add_beat('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (deque_fill == 0)
                begin
                    add_beat('0, ST_EMPTY, 1'b1);
                    empty_hits++;
                end
                else
                begin
                    if (operation == OP_POP_FRONT)
                    begin
                        slot = deque_head;
                        deque_head = wrap_slot(deque_head, 1);
                    end
                    else
                    begin
                        slot = wrap_slot(deque_head, deque_fill - 1);
                    end
                    deque_fill = deque_fill - 1'b1;
                    add_beat(deque_slots[slot], ST_OK, 1'b1);
                end
            end
            OP_READ_FWD, OP_READ_BWD:
            begin
                n = deque_fill;
                if (n == 0)
                begin
                    add_beat('0, ST_EMPTY, 1'b1);
                    empty_hits++;
                end
                for (int i = 0; i < n; i++)
                begin
                    off = (operation == OP_READ_FWD) ? i : n - 1 - i;
                    add_beat(deque_slots[wrap_slot(deque_head, off)], ST_OK, i == n - 1);
                end
            end
            default:
            begin
                // spare codes: nothing happens
            end
        endcase
    endtask

    // queue a request and keep a rough occupancy for steering the random walk
    task automatic offer_request(input logic [OP_W-1:0] operation,
                                 input logic signed [VALUE_W-1:0] word);
        req_item_t item;
        item.operation = operation;
        item.value     = word;
        pending_reqs.push_back(item);
        if ((operation == OP_PUSH_FRONT || operation == OP_PUSH_BACK) && gen_fill < DEPTH)
        begin
            gen_fill++;
        end
        else if ((operation == OP_POP_FRONT || operation == OP_POP_BACK) && gen_fill > 0)
        begin
            gen_fill--;
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        while ((pending_reqs.size() != 0 || expected_beats.size() != 0) &&
               waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic run_random_chunk(input int count);
        walk_mode_t walk_mode;
        int overrun_left;
        int mixed_left;
        int counted;
        int roll;
        logic [OP_W-1:0] op;
        walk_mode    = MODE_FILL;
        overrun_left = $urandom_range(0, 3);
        mixed_left   = 0;
        counted      = 0;
        while (counted < count)
        begin
            // turn the walk around at full, go to a mixed stretch at empty, overrunning by up to three requests
            if (walk_mode == MODE_FILL && gen_fill == DEPTH)
            begin
                if (overrun_left == 0)
                begin
                    walk_mode = MODE_DRAIN;
                    overrun_left = $urandom_range(0, 3);
                end
                else
                begin
                    overrun_left--;
                end
            end
            else if (walk_mode == MODE_DRAIN && gen_fill == 0)
            begin
                if (overrun_left == 0)
                begin
                    walk_mode = MODE_MIXED;
                    mixed_left = $urandom_range(8, 30);
                end
                else
                begin
                    overrun_left--;
                end
            end
            else if (walk_mode == MODE_MIXED)
            begin
                if (mixed_left == 0)
                begin
                    walk_mode = MODE_FILL;
                    overrun_left = $urandom_range(0, 3);
                end
                else
                begin
                    mixed_left--;
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                op = ($urandom_range(0, 1) == 0) ? OP_RSVD_LO : OP_RSVD_HI;
            end
            else if (walk_mode == MODE_MIXED)
            begin
                op = OP_W'($urandom_range(OP_PUSH_FRONT, OP_READ_BWD));
            end
            else
            begin
                if (roll < 75)
                begin
                    op = (walk_mode == MODE_FILL) ? OP_PUSH_FRONT : OP_POP_FRONT;
                end
                else if (roll < 87)
                begin
                    op = (walk_mode == MODE_FILL) ? OP_POP_FRONT : OP_PUSH_FRONT;
                end
                else
                begin
                    op = OP_READ_FWD;
                end
                // pick the front or back flavour of the chosen kind
                op = op | OP_W'($urandom_range(0, 1));
            end
            offer_request(op, $urandom);
            if (op != OP_RSVD_LO && op != OP_RSVD_HI)
            begin
                counted++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_PUSH_FRONT;
        req_ch.value        = '0;
        rsp_ch.ready        = 1'b0;
        deque_head          = '0;
        deque_fill          = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("run timed out with %0d beats still expected", expected_beats.size());
        $display("CHECK FAILED");
        $finish;
    end

    // receiver long hold-off while the sender keeps offering
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // request driver
    always @(negedge clk)
    begin
        if (req_took)
        begin
            req_took = 1'b0;
            offer_held = 1'b0;
            if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(1, 12);
            end
        end
        else
        begin
            offer_held = req_ch.valid;
        end
        if (!offer_held)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_ch.valid     <= 1'b1;
                req_ch.operation <= pending_reqs[0].operation;
                req_ch.value     <= pending_reqs[0].value;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            recv_gap = recv_gap - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (long_hold)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            recv_gap = $urandom_range(1, 12) - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // request acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_deque(req_ch.operation, req_ch.value);
            void'(pending_reqs.pop_front());
            req_took = 1'b1;
            if (req_ch.operation == OP_RSVD_LO || req_ch.operation == OP_RSVD_HI)
            begin
                noise_taken++;
            end
            else
            begin
                items_taken++;
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected response beat value %0d status %0d",
                                          rsp_ch.result_value, rsp_ch.status));
            end
            else
            begin
                due_beat = expected_beats.pop_front();
                if (rsp_ch.result_value !== due_beat.result_value)
                begin
                    report_mismatch($sformatf("result_value %0d, wanted %0d",
                                              rsp_ch.result_value, due_beat.result_value));
                end
                if (rsp_ch.status !== due_beat.status)
                begin
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp_ch.status, due_beat.status));
                end
                if (rsp_ch.last !== due_beat.last)
                begin
                    report_mismatch($sformatf("last %0b, wanted %0b",
                                              rsp_ch.last, due_beat.last));
                end
            end
        end
    end

    // stimulus
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);

        // empty deque, spare code, extreme words, fill to the brim, overflow, read-outs both ways, pops
        offer_request(OP_POP_FRONT, 32'sh1234_5678);
        offer_request(OP_POP_BACK, -32'sd1);
        offer_request(OP_READ_FWD, '0);
        offer_request(OP_RSVD_LO, 32'sh7FFF_FFFF);
        offer_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        offer_request(OP_PUSH_FRONT, 32'sh8000_0000);
        offer_request(OP_PUSH_BACK, '0);
        offer_request(OP_PUSH_FRONT, -32'sd1);
        for (int i = 0; i < DEPTH - 4; i++)
        begin
            offer_request((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                          (i % 2 == 0) ? 32'sh5555_5555 : 32'shAAAA_AAAA);
        end
        offer_request(OP_PUSH_FRONT, 32'sh0BAD_F00D);
        offer_request(OP_PUSH_BACK, 32'sh0BAD_F00D);
        offer_request(OP_READ_FWD, '0);
        offer_request(OP_READ_BWD, '0);
        offer_request(OP_POP_FRONT, '0);
        offer_request(OP_POP_BACK, '0);
        wait_for_drain();

        // random walk; hold the response side off early on so the core backs up
        run_random_chunk(110);
        hold_go = 1'b1;
        wait_for_drain();

        run_random_chunk(120);
        wait_for_drain();

        @(posedge clk);
        // drop any idle stretch still running so the tail goes at full rate
        quiet_tail = 1'b1;
        send_gap   = 0;
        recv_gap   = 0;
        run_random_chunk(100);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_beats.size() != 0)
        begin
            report_mismatch($sformatf("%0d response beats never arrived",
                                      expected_beats.size()));
        end
        $display("Covered %0d requests and %0d spare codes, %0d response beats checked.",
                 items_taken, noise_taken, beats_seen);
        $display("Full-deque pushes: %0d, empty-deque reports: %0d.", full_hits, empty_hits);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
